// ----- rtl/lltabe_pkg.sv -----
// Shared types and constants for the linked list table engine.
// Holds the transfer structs, memory command structs and table sizing.
// No dependencies.
`default_nettype none

package lltabe_pkg;

   localparam int NODE_COUNT = 1024;
   localparam int PTR_W      = 10;
   localparam int ADDR_W     = $clog2(NODE_COUNT);
   localparam int LWORD_W    = PTR_W + 1;
   localparam int FLAG_BIT   = PTR_W;

   typedef logic [PTR_W-1:0]   ptr_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [LWORD_W-1:0] lword_type;

   localparam lword_type LPTR_MASK  = {1'b0, {PTR_W{1'b1}}};
   localparam lword_type LFLAG_MASK = {1'b1, {PTR_W{1'b0}}};
   localparam lword_type LFULL_MASK = {LWORD_W{1'b1}};

   typedef enum logic [1:0] {
      OP_INSERT_LEFT  = 2'd0,
      OP_INSERT_RIGHT = 2'd1,
      OP_REMOVE       = 2'd2,
      OP_READ         = 2'd3
   } op_type;

   typedef struct packed {
      op_type  operation;
      ptr_type node;
      ptr_type anchor;
   } req_type;

   typedef struct packed {
      ptr_type left_neighbour;
      ptr_type right_neighbour;
      logic    is_removed;
   } rsp_type;

   typedef struct packed {
      logic      rd_en;
      addr_type  rd_addr;
      lword_type wr_mask;
      addr_type  wr_addr;
      lword_type wr_data;
   } lmem_cmd_type;

   typedef struct packed {
      logic     rd_en;
      addr_type rd_addr;
      ptr_type  wr_mask;
      addr_type wr_addr;
      ptr_type  wr_data;
   } rmem_cmd_type;

   function automatic addr_type to_addr(ptr_type p);
      return ADDR_W'(p);
   endfunction

   function automatic logic in_table(ptr_type p);
      return int'(p) < NODE_COUNT;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/lltabe_ram.sv -----
// Single write port, single read port synchronous RAM with per-bit write mask.
// Read data is registered. No package dependencies.
`default_nettype none

module lltabe_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data,
   input  wire logic [WIDTH-1:0] wr_mask,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < WIDTH; i++) begin
         if (wr_mask[i]) begin
            mem[wr_addr][i] <= wr_data[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/lltabe_seq.sv -----
// Operation sequencer: decodes a request, reads the link tables, then
// issues the pointer write-backs in a fixed order. Depends on lltabe_pkg.
`default_nettype none

module lltabe_seq import lltabe_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_type      req_data,
   input  wire logic         out_free,
   output logic              res_valid,
   output rsp_type           res_data,
   output lmem_cmd_type      lmem_cmd,
   input  wire lword_type    lmem_rd_data,
   output rmem_cmd_type      rmem_cmd,
   input  wire ptr_type      rmem_rd_data
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_STEP1 = 5'b00100,
      ST_STEP2 = 5'b01000,
      ST_HOLD  = 5'b10000
   } state_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_READ,
      ACT_INS_LEFT,
      ACT_INS_RIGHT,
      ACT_REMOVE
   } act_type;

   state_type state_ff, state_in;
   addr_type  clr_addr_ff, clr_addr_in;
   act_type   act_ff, act_dec;
   ptr_type   node_ff;
   ptr_type   anchor_ff;

   logic      accept;
   logic      linkable;
   logic      finish;
   logic      two_step;
   ptr_type   ptr_l;
   ptr_type   ptr_r;
   logic      flag;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);

   assign linkable = in_table(req_data.anchor) && (req_data.anchor != req_data.node);

   always_comb begin
      act_dec = ACT_READ;
      if (!in_table(req_data.node)) begin
         act_dec = ACT_NONE;
      end else if (req_data.node != '0) begin
         case (req_data.operation)
            OP_INSERT_LEFT:  act_dec = linkable ? ACT_INS_LEFT : ACT_READ;
            OP_INSERT_RIGHT: act_dec = linkable ? ACT_INS_RIGHT : ACT_READ;
            OP_REMOVE:       act_dec = ACT_REMOVE;
            default:         act_dec = ACT_READ;
         endcase
      end
   end

   assign ptr_l = lmem_rd_data[PTR_W-1:0];
   assign flag  = lmem_rd_data[FLAG_BIT];
   assign ptr_r = rmem_rd_data;

   assign two_step = (act_ff == ACT_INS_LEFT) || (act_ff == ACT_INS_RIGHT) ||
                     ((act_ff == ACT_REMOVE) && !flag);

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      finish      = 1'b0;

      lmem_cmd.rd_en   = accept;
      lmem_cmd.rd_addr = (act_dec == ACT_INS_LEFT) ? to_addr(req_data.anchor)
                                                   : to_addr(req_data.node);
      lmem_cmd.wr_mask = '0;
      lmem_cmd.wr_addr = to_addr(node_ff);
      lmem_cmd.wr_data = '0;

      rmem_cmd.rd_en   = accept;
      rmem_cmd.rd_addr = (act_dec == ACT_INS_RIGHT) ? to_addr(req_data.anchor)
                                                    : to_addr(req_data.node);
      rmem_cmd.wr_mask = '0;
      rmem_cmd.wr_addr = to_addr(node_ff);
      rmem_cmd.wr_data = '0;

      case (state_ff)
         ST_CLEAR: begin
            lmem_cmd.wr_mask = LFULL_MASK;
            lmem_cmd.wr_addr = clr_addr_ff;
            lmem_cmd.wr_data = (clr_addr_ff == '0) ? {1'b0, PTR_W'(1)} : '0;
            rmem_cmd.wr_mask = '1;
            rmem_cmd.wr_addr = clr_addr_ff;
            rmem_cmd.wr_data = (clr_addr_ff == '0) ? PTR_W'(1) : '0;
            clr_addr_in      = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(NODE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_STEP1;
            end
         end
         ST_STEP1: begin
            case (act_ff)
               ACT_INS_LEFT: begin
                  lmem_cmd.wr_mask = LFULL_MASK;
                  lmem_cmd.wr_data = {1'b0, ptr_l};
                  rmem_cmd.wr_mask = '1;
                  if (ptr_l == node_ff) begin
                     rmem_cmd.wr_data = anchor_ff;
                  end else begin
                     rmem_cmd.wr_addr = to_addr(ptr_l);
                     rmem_cmd.wr_data = node_ff;
                  end
               end
               ACT_INS_RIGHT: begin
                  rmem_cmd.wr_mask = '1;
                  rmem_cmd.wr_data = ptr_r;
                  if (ptr_r == node_ff) begin
                     lmem_cmd.wr_mask = LFULL_MASK;
                     lmem_cmd.wr_data = {1'b0, anchor_ff};
                  end else begin
                     lmem_cmd.wr_mask = LPTR_MASK;
                     lmem_cmd.wr_addr = to_addr(ptr_r);
                     lmem_cmd.wr_data = {1'b0, node_ff};
                  end
               end
               ACT_REMOVE: begin
                  if (!flag) begin
                     lmem_cmd.wr_mask = LFLAG_MASK;
                     lmem_cmd.wr_data = LFLAG_MASK;
                     rmem_cmd.wr_mask = '1;
                     rmem_cmd.wr_addr = to_addr(ptr_l);
                     rmem_cmd.wr_data = ptr_r;
                  end
               end
               default: begin
               end
            endcase
            if (two_step) begin
               state_in = ST_STEP2;
            end else begin
               finish = 1'b1;
            end
         end
         ST_STEP2: begin
            case (act_ff)
               ACT_INS_LEFT: begin
                  lmem_cmd.wr_mask = LPTR_MASK;
                  lmem_cmd.wr_addr = to_addr(anchor_ff);
                  lmem_cmd.wr_data = {1'b0, node_ff};
                  rmem_cmd.wr_mask = '1;
                  rmem_cmd.wr_data = anchor_ff;
               end
               ACT_INS_RIGHT: begin
                  rmem_cmd.wr_mask = '1;
                  rmem_cmd.wr_addr = to_addr(anchor_ff);
                  rmem_cmd.wr_data = node_ff;
                  lmem_cmd.wr_mask = LFULL_MASK;
                  lmem_cmd.wr_data = {1'b0, anchor_ff};
               end
               ACT_REMOVE: begin
                  lmem_cmd.wr_mask = LPTR_MASK;
                  lmem_cmd.wr_addr = to_addr(ptr_r);
                  lmem_cmd.wr_data = {1'b0, ptr_l};
               end
               default: begin
               end
            endcase
            finish = 1'b1;
         end
         ST_HOLD: begin
            finish = 1'b1;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      if (finish) begin
         state_in = out_free ? ST_IDLE : ST_HOLD;
      end
   end

   assign res_valid = finish && out_free;

   always_comb begin
      case (act_ff)
         ACT_INS_LEFT:  res_data = '{left_neighbour: ptr_l, right_neighbour: anchor_ff,
                                    is_removed: 1'b0};
         ACT_INS_RIGHT: res_data = '{left_neighbour: anchor_ff, right_neighbour: ptr_r,
                                    is_removed: 1'b0};
         ACT_REMOVE:    res_data = '{left_neighbour: ptr_l, right_neighbour: ptr_r,
                                    is_removed: 1'b1};
         ACT_READ:      res_data = '{left_neighbour: ptr_l, right_neighbour: ptr_r,
                                    is_removed: flag};
         default:       res_data = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff    <= act_dec;
         node_ff   <= req_data.node;
         anchor_ff <= req_data.anchor;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/linked_list_table_engine_core.sv -----
// Top level of the linked list table engine: link table RAMs, sequencer and
// response register. Depends on lltabe_pkg, lltabe_ram and lltabe_seq.
`default_nettype none

// After reset the block sweeps all NODE_COUNT (1024) entries of both link
// tables, one entry per cycle, before it takes its first request. Then each
// request reads the tables once. An insert or a first removal writes back
// in the states STEP1 and STEP2, as each link table has one write port that
// takes one pointer per cycle; a read, a repeated removal or an ignored
// request ends in STEP1. No new request is taken until the sequencer is idle.
// The response register frees the sequencer while a result waits; a stalled
// response holds the sequencer only when a second result is due.
module linked_list_table_engine_core import lltabe_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   lmem_cmd_type lmem_cmd;
   rmem_cmd_type rmem_cmd;
   lword_type    lmem_rd_data;
   ptr_type      rmem_rd_data;
   logic         res_valid;
   rsp_type      res_data;
   logic         out_free;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff;

   lltabe_ram #(
      .WIDTH (LWORD_W),
      .DEPTH (NODE_COUNT)
   ) u_left_ram (
      .clock   (clock),
      .rd_en   (lmem_cmd.rd_en),
      .rd_addr (lmem_cmd.rd_addr),
      .rd_data (lmem_rd_data),
      .wr_mask (lmem_cmd.wr_mask),
      .wr_addr (lmem_cmd.wr_addr),
      .wr_data (lmem_cmd.wr_data)
   );

   lltabe_ram #(
      .WIDTH (PTR_W),
      .DEPTH (NODE_COUNT)
   ) u_right_ram (
      .clock   (clock),
      .rd_en   (rmem_cmd.rd_en),
      .rd_addr (rmem_cmd.rd_addr),
      .rd_data (rmem_rd_data),
      .wr_mask (rmem_cmd.wr_mask),
      .wr_addr (rmem_cmd.wr_addr),
      .wr_data (rmem_cmd.wr_data)
   );

   lltabe_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .out_free     (out_free),
      .res_valid    (res_valid),
      .res_data     (res_data),
      .lmem_cmd     (lmem_cmd),
      .lmem_rd_data (lmem_rd_data),
      .rmem_cmd     (rmem_cmd),
      .rmem_rd_data (rmem_rd_data)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- rtl/lltabe_checker.sv -----
// Port-level checker for the linked list table engine, bound to the top level.
// Depends on linked_list_table_engine_core.
`default_nettype none

module lltabe_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall
);

   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request port open right after reset");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken in back-to-back cycles");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response raised without work in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled response dropped");

endmodule

bind linked_list_table_engine_core lltabe_checker u_lltabe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Testbench for linked_list_table_engine_core: directed and random list operations.
// Keeps its own copy of the link tables to predict each response.
// Depends on lltabe_pkg and the RTL of the engine.
module testbench;
   import lltabe_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int idle_pct = 0;
   int stall_pct = 0;
   int error_count = 0;

   ptr_type left_tbl  [NODE_COUNT];
   ptr_type right_tbl [NODE_COUNT];
   bit      gone      [NODE_COUNT];
   bit      left_ok   [NODE_COUNT];
   bit      right_ok  [NODE_COUNT];
   bit      mapped    [NODE_COUNT];
   int      mapped_nodes [$];
   rsp_type due_neighbours [$];

   linked_list_table_engine_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   function automatic void note_mapped(ptr_type idx);
      if (left_ok[idx] && right_ok[idx] && !mapped[idx]) begin
         mapped[idx] = 1'b1;
         mapped_nodes.push_back(int'(idx));
      end
   endfunction

   function automatic void set_left(ptr_type idx, ptr_type val);
      left_tbl[idx] = val;
      left_ok[idx] = 1'b1;
      note_mapped(idx);
   endfunction

   function automatic void set_right(ptr_type idx, ptr_type val);
      right_tbl[idx] = val;
      right_ok[idx] = 1'b1;
      note_mapped(idx);
   endfunction

   function automatic void clear_links();
      foreach (gone[i]) begin
         gone[i] = 1'b0;
         left_ok[i] = 1'b0;
         right_ok[i] = 1'b0;
         mapped[i] = 1'b0;
      end
      mapped_nodes.delete();
      set_left(ptr_type'(0), ptr_type'(1));
      set_right(ptr_type'(0), ptr_type'(1));
      set_left(ptr_type'(1), ptr_type'(0));
      set_right(ptr_type'(1), ptr_type'(0));
   endfunction

   function automatic rsp_type apply_list_op(req_type it);
      ptr_type n;
      ptr_type a;
      ptr_type l;
      ptr_type r;
      bit      n_ok;
      bit      a_ok;
      bit      insert;
      rsp_type res;
      n = it.node;
      a = it.anchor;
      n_ok = int'(n) < NODE_COUNT;
      a_ok = int'(a) < NODE_COUNT;
      insert = (it.operation == OP_INSERT_LEFT) || (it.operation == OP_INSERT_RIGHT);
      if (n_ok && n != 0) begin
         if (insert && a_ok && a != n) begin
            if (it.operation == OP_INSERT_LEFT) begin
               l = left_tbl[a];
               set_left(n, l);
               set_right(l, n);
               set_left(a, n);
               set_right(n, a);
            end else begin
               r = right_tbl[a];
               set_right(n, r);
               set_left(r, n);
               set_right(a, n);
               set_left(n, a);
            end
            gone[n] = 1'b0;
         end else if (it.operation == OP_REMOVE && !gone[n]) begin
            gone[n] = 1'b1;
            l = left_tbl[n];
            r = right_tbl[n];
            set_right(l, r);
            set_left(r, l);
         end
      end
      res = '0;
      if (n_ok) begin
         res.left_neighbour = left_tbl[n];
         res.right_neighbour = right_tbl[n];
         res.is_removed = gone[n];
      end
      return res;
   endfunction

   function automatic bit safe_to_issue(req_type it);
      ptr_type n;
      ptr_type a;
      n = it.node;
      a = it.anchor;
      if (n == 0) return 1'b1;
      if (it.operation == OP_INSERT_LEFT && a != n) return left_ok[a];
      if (it.operation == OP_INSERT_RIGHT && a != n) return right_ok[a];
      return left_ok[n] && right_ok[n];
   endfunction

   function automatic ptr_type pick_mapped();
      return ptr_type'(mapped_nodes[$urandom_range(mapped_nodes.size() - 1)]);
   endfunction

   function automatic req_type pick_random_op();
      req_type it;
      int      r;
      do begin
         r = $urandom_range(99);
         it.anchor = ptr_type'($urandom_range(NODE_COUNT - 1));
         it.node = pick_mapped();
         if (r < 45) begin
            it.operation = $urandom_range(1) ? OP_INSERT_RIGHT : OP_INSERT_LEFT;
            if ($urandom_range(9) != 0) it.node = ptr_type'($urandom_range(NODE_COUNT - 1));
            it.anchor = pick_mapped();
            if ($urandom_range(29) == 0) it.anchor = it.node;
         end else if (r < 65) begin
            it.operation = OP_REMOVE;
         end else if (r < 92) begin
            it.operation = OP_READ;
         end else begin
            it.operation = op_type'($urandom_range(3));
            it.node = '0;
         end
      end while (!safe_to_issue(it));
      return it;
   endfunction

   task automatic send_item(input req_type it);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do begin
         @(posedge clock);
      end while (req_stall);
      due_neighbours.push_back(apply_list_op(it));
   endtask

   task automatic send_op(input op_type op, input int node, input int anchor);
      req_type it;
      it.operation = op;
      it.node = ptr_type'(node);
      it.anchor = ptr_type'(anchor);
      send_item(it);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_neighbours.size() == 0) begin
            $error("unexpected response transfer");
            error_count++;
         end else begin
            want = due_neighbours.pop_front();
            if (rsp_data.left_neighbour !== want.left_neighbour) begin
               $error("left_neighbour: expected %0d, actual %0d",
                      want.left_neighbour, rsp_data.left_neighbour);
               error_count++;
            end
            if (rsp_data.right_neighbour !== want.right_neighbour) begin
               $error("right_neighbour: expected %0d, actual %0d",
                      want.right_neighbour, rsp_data.right_neighbour);
               error_count++;
            end
            if (rsp_data.is_removed !== want.is_removed) begin
               $error("is_removed: expected %0d, actual %0d",
                      want.is_removed, rsp_data.is_removed);
               error_count++;
            end
         end
      end
   end

   task automatic test_reset_links();
      send_op(OP_READ, 0, 0);
      send_op(OP_READ, 1, 1023);
      send_op(OP_READ, 1, 0);
   endtask

   task automatic test_insert_ends();
      send_op(OP_INSERT_RIGHT, 1023, 0);
      send_op(OP_INSERT_LEFT, 512, 0);
      send_op(OP_INSERT_LEFT, 2, 1);
      send_op(OP_INSERT_RIGHT, 768, 1023);
      send_op(OP_READ, 0, 512);
   endtask

   task automatic test_ignored_ops();
      send_op(OP_INSERT_LEFT, 0, 1);
      send_op(OP_INSERT_RIGHT, 0, 512);
      send_op(OP_INSERT_LEFT, 1, 1);
      send_op(OP_REMOVE, 0, 1023);
      send_op(OP_READ, 0, 0);
   endtask

   task automatic test_remove_twice();
      send_op(OP_REMOVE, 2, 0);
      send_op(OP_REMOVE, 2, 0);
      send_op(OP_READ, 2, 0);
      send_op(OP_REMOVE, 1023, 0);
      send_op(OP_READ, 0, 0);
   endtask

   task automatic test_reinsertion();
      send_op(OP_INSERT_RIGHT, 2, 512);
      send_op(OP_INSERT_LEFT, 768, 512);
      send_op(OP_INSERT_RIGHT, 341, 768);
      send_op(OP_INSERT_LEFT, 682, 341);
      send_op(OP_READ, 682, 0);
   endtask

   task automatic test_random_traffic(input int count, input int idle, input int stall);
      idle_pct = idle;
      stall_pct = stall;
      repeat (count) send_item(pick_random_op());
   endtask

   initial begin
      clear_links();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_links();
      test_insert_ends();
      test_ignored_ops();
      test_remove_twice();
      test_reinsertion();
      test_random_traffic(100, 0, 0);
      test_random_traffic(100, 62, 0);
      test_random_traffic(100, 0, 62);
      test_random_traffic(100, 7, 7);
      req_valid <= 1'b0;
      while (due_neighbours.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/lltabe_pkg.sv
rtl/lltabe_ram.sv
rtl/lltabe_seq.sv
rtl/linked_list_table_engine_core.sv
rtl/lltabe_checker.sv
tb/sv/testbench.sv
